// File: src/rsoc_pkg.sv
// Shared types and constants for the rate sensor offset calibration block.
// No dependencies; imported by every module of the block.
package rsoc_pkg;

  // Default widths of the sample and run-counter paths.
  localparam int SampleBitsDef = 16;
  localparam int CountBitsDef  = 16;

  // Fixed register field widths.
  localparam int DzW  = 15;
  localparam int CalW = 16;
  localparam int SetW = 10;

  // APB register file geometry.
  localparam int AddrW = 4;
  localparam int DataW = 32;

  // Register reset values.
  localparam logic [DzW-1:0]  DeadZoneRst = DzW'(3);
  localparam logic [CalW-1:0] CalibRst    = CalW'(200);
  localparam logic [SetW-1:0] SettleRst   = SetW'(300);

  // Register indexes (byte address / 4).
  localparam logic [1:0] RegDeadZone = 2'd0;
  localparam logic [1:0] RegCalib    = 2'd1;
  localparam logic [1:0] RegSettle   = 2'd2;

  // Input opcodes.
  localparam logic OpSample = 1'b0;
  localparam logic OpCalib  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_ACCUM,
    ST_DIV_START,
    ST_DIV_WAIT
  } state_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic [DzW-1:0]  dz_width;
    logic [CalW-1:0] calib;
    logic [SetW-1:0] settle;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic  clear;      // start of run: clear sums and counter
    logic  cnt_inc;    // advance run counter
    logic  cnt_clr;    // end of phase: clear run counter
    logic  accum;      // add sample into sums
    logic  latch_div;  // capture divisor at run completion
    logic  load_out;   // load result register
    logic  div_start;  // launch division for axis
    logic  wr_offset;  // store quotient into offset for axis
    axis_e axis;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic settle_zero;
    logic settle_hit;
    logic accum_hit;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: src/rsoc_regs.sv
// APB register file for dead zone, calibration count and settle count.
// Depends on rsoc_pkg.
module rsoc_regs
  import rsoc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        RegDeadZone: cfg_d.dz_width = pwdata[DzW-1:0];
        RegCalib:    cfg_d.calib    = pwdata[CalW-1:0];
        RegSettle:   cfg_d.settle   = pwdata[SetW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegDeadZone: prdata = DataW'(cfg_q.dz_width);
      RegCalib:    prdata = DataW'(cfg_q.calib);
      RegSettle:   prdata = DataW'(cfg_q.settle);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dz_width <= DeadZoneRst;
      cfg_q.calib    <= CalibRst;
      cfg_q.settle   <= SettleRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/rsoc_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on rsoc_pkg.
module rsoc_div
  import rsoc_pkg::*;
#(
  parameter int SumW = SampleBitsDef + CountBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] dividend_i,
  input  logic [CalW-1:0]        divisor_i,
  output logic                   done_o,
  output logic signed [SumW-1:0] quot_o
);

  localparam int CntW = $clog2(SumW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CalW-1:0] rem_q, rem_d;
  logic [SumW-1:0] quo_q, quo_d;
  logic            neg_q, neg_d;
  logic [CalW:0]   trial;
  logic [CalW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quo_q[SumW-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      neg_d  = dividend_i[SumW-1];
      quo_d  = dividend_i[SumW-1] ? (~dividend_i + SumW'(1)) : dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[CalW-1:0] : trial[CalW-1:0];
      quo_d = {quo_q[SumW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(~quo_q + SumW'(1)) : $signed(quo_q);

endmodule

// File: src/rsoc_ctrl.sv
// Calibration sequencer: run phases, input handshake and per-axis division.
// Depends on rsoc_pkg.
module rsoc_ctrl
  import rsoc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    opcode_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  axis_e  axis_q, axis_d;
  logic   in_fire;

  assign in_ready_o = (state_q inside {ST_IDLE, ST_SETTLE, ST_ACCUM}) && status_i.out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    case (state_q)
      ST_IDLE, ST_SETTLE, ST_ACCUM: begin
        if (in_fire) begin
          if (opcode_i == OpCalib) begin
            cmd_o.clear = 1'b1;
            state_d = status_i.settle_zero ? ST_ACCUM : ST_SETTLE;
          end else if (state_q == ST_SETTLE) begin
            cmd_o.cnt_inc = 1'b1;
            if (status_i.settle_hit) begin
              cmd_o.cnt_clr = 1'b1;
              state_d = ST_ACCUM;
            end
          end else if (state_q == ST_ACCUM) begin
            cmd_o.accum   = 1'b1;
            cmd_o.cnt_inc = 1'b1;
            if (status_i.accum_hit) begin
              cmd_o.cnt_clr   = 1'b1;
              cmd_o.latch_div = 1'b1;
              axis_d  = AXIS_X;
              state_d = ST_DIV_START;
            end
          end else begin
            cmd_o.load_out = 1'b1;
          end
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.wr_offset = 1'b1;
          case (axis_q)
            AXIS_X: begin
              axis_d  = AXIS_Y;
              state_d = ST_DIV_START;
            end
            AXIS_Y: begin
              axis_d  = AXIS_Z;
              state_d = ST_DIV_START;
            end
            default: begin
              axis_d  = AXIS_X;
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= AXIS_X;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

endmodule

// File: src/rsoc_dp.sv
// Datapath: run counter, per-axis sums and offsets, divider, dead zone and
// result register. Depends on rsoc_pkg and rsoc_div.
module rsoc_dp
  import rsoc_pkg::*;
#(
  parameter int SampleBits = SampleBitsDef,
  parameter int CountBits  = CountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  cmd_t                       cmd_i,
  input  logic signed [SampleBits-1:0] raw_i [3],
  input  logic                       out_ready_i,
  output status_t                    status_o,
  output logic                       out_valid_o,
  output logic signed [SampleBits:0] rate_o [3],
  output logic signed [SampleBits-1:0] bias_o [3]
);

  localparam int SumW = SampleBits + CountBits;
  localparam int CmpW = (CountBits > CalW) ? CountBits : CalW;

  logic [CountBits-1:0]      cnt_q, cnt_d, cnt_inc;
  logic [CalW-1:0]           target;
  logic [CalW-1:0]           divisor_q;
  logic signed [SumW-1:0]    sum_q [3];
  logic signed [SumW-1:0]    offset_q [3];
  logic signed [SumW-1:0]    dividend;
  logic signed [SumW-1:0]    quot;
  logic                      div_done;
  logic signed [SumW:0]      dz_pos;
  logic signed [SumW:0]      diff [3];
  logic signed [SampleBits:0] rate_d [3];
  logic                      out_valid_q, out_valid_d;
  logic signed [SampleBits:0]  rate_q [3];
  logic signed [SampleBits-1:0] bias_q [3];

  // Zero calibration count behaves as one.
  assign target  = (cfg_i.calib == '0) ? CalW'(1) : cfg_i.calib;
  assign cnt_inc = cnt_q + CountBits'(1);

  assign status_o.settle_zero = (cfg_i.settle == '0);
  assign status_o.settle_hit  = CmpW'(cnt_inc) >= CmpW'(cfg_i.settle);
  assign status_o.accum_hit   = CmpW'(cnt_inc) >= CmpW'(target);
  assign status_o.div_done    = div_done;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear || cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        sum_q[a]    <= '0;
        offset_q[a] <= '0;
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        if (cmd_i.clear) begin
          sum_q[a] <= '0;
        end else if (cmd_i.accum) begin
          sum_q[a] <= sum_q[a] + SumW'(raw_i[a]);
        end
      end
      if (cmd_i.wr_offset) begin
        offset_q[cmd_i.axis] <= quot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_div) begin
      divisor_q <= target;
    end
  end

  assign dividend = sum_q[cmd_i.axis];

  rsoc_div #(
    .SumW(SumW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Full-width difference; dead zone test before truncation to the port width.
  assign dz_pos = $signed({{(SumW + 1 - DzW){1'b0}}, cfg_i.dz_width});

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = (SumW + 1)'(raw_i[a]) - (SumW + 1)'(offset_q[a]);
      if (diff[a] < dz_pos && diff[a] > -dz_pos) begin
        rate_d[a] = '0;
      end else begin
        rate_d[a] = diff[a][SampleBits:0];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      for (int a = 0; a < 3; a++) begin
        rate_q[a] <= rate_d[a];
        bias_q[a] <= offset_q[a][SampleBits-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign rate_o      = rate_q;
  assign bias_o      = bias_q;

endmodule

// File: src/rate_sensor_offset_calib_deadzone_unit.sv
// Top level of the rate sensor offset calibration block with dead zone.
// Depends on rsoc_pkg, rsoc_regs, rsoc_ctrl and rsoc_dp.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries an opcode and three raw
//   axis samples. Opcode OpCalib starts (or restarts) a calibration run; a
//   sample during a run is dropped while settling, then summed per axis.
//   Output channel (out_valid_o/out_ready_i) carries one transaction per
//   sample taken outside a run: offset-corrected, dead-zoned rates plus the
//   offsets in force. Start opcodes and run samples give no transaction.
//   out_valid_o rises in the cycle after input acceptance. Throughput is
//   one transaction per cycle while the receiver takes results and no
//   division runs: the result register frees in the same cycle the receiver
//   takes its transaction. The sample that completes a run launches three
//   divisions on one shared radix-2 divider, one axis after another; each
//   is launched, iterates and writes its offset back, and in_ready_o stays
//   low until all three are done.
//   When the receiver stalls with a result held, in_ready_o drops and the
//   held transaction stays unchanged until taken.
//   Reset clears offsets, sums and the run counter, leaves the block out of
//   calibration and loads the register defaults (dead zone 3, count 200,
//   settle 300). Registers sit on the APB port at byte addresses 0, 4, 8.
module rate_sensor_offset_calib_deadzone_unit
  import rsoc_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int COUNT_BITS  = CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic signed [SAMPLE_BITS-1:0] raw_x_i,
  input  logic signed [SAMPLE_BITS-1:0] raw_y_i,
  input  logic signed [SAMPLE_BITS-1:0] raw_z_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SAMPLE_BITS:0]  rate_x_o,
  output logic signed [SAMPLE_BITS:0]  rate_y_o,
  output logic signed [SAMPLE_BITS:0]  rate_z_o,
  output logic signed [SAMPLE_BITS-1:0] bias_x_o,
  output logic signed [SAMPLE_BITS-1:0] bias_y_o,
  output logic signed [SAMPLE_BITS-1:0] bias_z_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [AddrW-1:0]             paddr,
  input  logic [DataW-1:0]             pwdata,
  output logic [DataW-1:0]             prdata,
  output logic                         pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  logic signed [SAMPLE_BITS-1:0] raw_a  [3];
  logic signed [SAMPLE_BITS:0]   rate_a [3];
  logic signed [SAMPLE_BITS-1:0] bias_a [3];

  assign raw_a[0] = raw_x_i;
  assign raw_a[1] = raw_y_i;
  assign raw_a[2] = raw_z_i;

  rsoc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequence run phases and divisions; own the input handshake.
  rsoc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // Hold sums, offsets and the result register.
  rsoc_dp #(
    .SampleBits (SAMPLE_BITS),
    .CountBits  (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .raw_i       (raw_a),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .rate_o      (rate_a),
    .bias_o      (bias_a)
  );

  assign rate_x_o = rate_a[0];
  assign rate_y_o = rate_a[1];
  assign rate_z_o = rate_a[2];
  assign bias_x_o = bias_a[0];
  assign bias_y_o = bias_a[1];
  assign bias_z_o = bias_a[2];

`ifndef SYNTH
  // A new result appears only after a sample transaction was taken.
  a_out_from_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && (opcode_i == OpSample)))
    else $error("result appeared without an accepted sample");

  // Input stays blocked while a division is launched.
  a_block_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !in_ready_o)
    else $error("input accepted during offset division");

  // Result register loads only on an accepted sample transaction.
  a_load_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (in_valid_i && in_ready_o && (opcode_i == OpSample)))
    else $error("result loaded without an accepted sample");
`endif

endmodule

// File: bench/tb_rate_sensor_offset_calib_deadzone_unit.sv
// Testbench for rate_sensor_offset_calib_deadzone_unit: directed and random samples and
// calibration runs, checked against an in-bench predictor of offsets and dead-zoned rates.
// Depends on rsoc_pkg and the RTL of the block only.
module tb_rate_sensor_offset_calib_deadzone_unit;
  import rsoc_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int QuietCycles = 150;  // long enough for the three serial divisions
  localparam int RandomItems = 400;

  typedef enum logic [1:0] {
    CAL_OFF,
    CAL_SETTLE,
    CAL_SUM
  } cal_phase_e;

  typedef struct packed {
    logic               op;
    logic signed [15:0] x, y, z;
  } sample_t;

  typedef struct packed {
    logic signed [16:0] rx, ry, rz;
    logic signed [15:0] bx, by, bz;
  } rate_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               opcode_i   = OpSample;
  logic signed [15:0] raw_x_i    = '0;
  logic signed [15:0] raw_y_i    = '0;
  logic signed [15:0] raw_z_i    = '0;

  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [16:0] rate_x_o, rate_y_o, rate_z_o;
  logic signed [15:0] bias_x_o, bias_y_o, bias_z_o;

  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  rate_sensor_offset_calib_deadzone_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .raw_x_i    (raw_x_i),
    .raw_y_i    (raw_y_i),
    .raw_z_i    (raw_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .rate_x_o   (rate_x_o),
    .rate_y_o   (rate_y_o),
    .rate_z_o   (rate_z_o),
    .bias_x_o   (bias_x_o),
    .bias_y_o   (bias_y_o),
    .bias_z_o   (bias_z_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the registers and of the calibration state.
  logic [DzW-1:0]     dz_cfg     = DeadZoneRst;
  logic [CalW-1:0]    count_cfg  = CalibRst;
  logic [SetW-1:0]    settle_cfg = SettleRst;
  longint             axis_bias [3] = '{0, 0, 0};
  longint             axis_sum [3]  = '{0, 0, 0};
  logic [15:0]        run_cnt   = '0;
  cal_phase_e         cal_phase = CAL_OFF;

  sample_t sample_q[$];        // samples waiting for the driver
  rate_t   pending_rates_q[$]; // corrected rates still owed by the block

  int run_ctr [3] = '{0, 0, 0}; // per-axis center of the latest calibration run
  int fed          = 0;
  int mismatch_cnt = 0;
  int cycle_cnt    = 0;
  bit calm         = 1'b0;       // no idling on either side when set
  int gap_left     = 0;
  int stall_left   = 0;

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 40) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    end
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  // Advance the calibration state by one accepted transaction; queue a rate if one is due.
  function automatic void apply_sample(input sample_t s);
    logic signed [15:0] raw [3];
    longint diff [3];
    int     width;
    longint divisor;
    rate_t  r;
    raw[0] = s.x;
    raw[1] = s.y;
    raw[2] = s.z;
    if (s.op == OpCalib) begin
      // Start or restart a run: drop the partial sums.
      foreach (axis_sum[i]) axis_sum[i] = 0;
      run_cnt   = '0;
      cal_phase = (settle_cfg == '0) ? CAL_SUM : CAL_SETTLE;
    end else begin
      case (cal_phase)
        CAL_SETTLE: begin
          run_cnt = run_cnt + 16'd1;
          if (run_cnt >= 16'(settle_cfg)) begin
            cal_phase = CAL_SUM;
            run_cnt   = '0;
          end
        end
        CAL_SUM: begin
          foreach (axis_sum[i]) axis_sum[i] += longint'(raw[i]);
          run_cnt = run_cnt + 16'd1;
          divisor = (count_cfg == '0) ? 64'sd1 : longint'(count_cfg);
          // Live register value: the run ends once the counter reaches or passes it.
          if (longint'(run_cnt) >= divisor) begin
            foreach (axis_bias[i]) axis_bias[i] = axis_sum[i] / divisor;
            cal_phase = CAL_OFF;
            run_cnt   = '0;
          end
        end
        default: begin
          width = int'(dz_cfg);
          foreach (raw[i]) begin
            diff[i] = longint'(raw[i]) - axis_bias[i];
            if (diff[i] < width && diff[i] > -width) diff[i] = 0;
          end
          r.rx = 17'(diff[0]);
          r.ry = 17'(diff[1]);
          r.rz = 17'(diff[2]);
          r.bx = 16'(axis_bias[0]);
          r.by = 16'(axis_bias[1]);
          r.bz = 16'(axis_bias[2]);
          pending_rates_q.push_back(r);
        end
      endcase
    end
  endfunction

  // Input driver: hold each transaction until accepted, idle in random bursts.
  always @(posedge clk_i) begin : driver
    sample_t next_item;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        apply_sample({opcode_i, raw_x_i, raw_y_i, raw_z_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 8);
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          next_item = sample_q.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= next_item.op;
          raw_x_i    <= next_item.x;
          raw_y_i    <= next_item.y;
          raw_z_i    <= next_item.z;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each transaction with the oldest owed rate, stall in bursts.
  always @(posedge clk_i) begin : monitor
    rate_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_rates_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, rate_x %0d", rate_x_o));
        end else begin
          want = pending_rates_q.pop_front();
          check_field("rate_x", rate_x_o, want.rx);
          check_field("rate_y", rate_y_o, want.ry);
          check_field("rate_z", rate_z_o, want.rz);
          check_field("bias_x", bias_x_o, want.bx);
          check_field("bias_y", bias_y_o, want.by);
          check_field("bias_z", bias_z_o, want.bz);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_read(input logic [1:0] idx, input int unsigned want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field($sformatf("register %0d readback", idx), prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input logic [1:0] idx, input int unsigned val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // The register takes the value at this edge.
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegDeadZone: dz_cfg    = DzW'(val);
      RegCalib:    count_cfg = CalW'(val);
      default:     settle_cfg = SetW'(val);
    endcase
    reg_read(idx, val);
  endtask

  function automatic void push_item(input logic op, input int x, input int y, input int z);
    sample_t s;
    s.op = op;
    s.x  = 16'(x);
    s.y  = 16'(y);
    s.z  = 16'(z);
    sample_q.push_back(s);
  endfunction

  function automatic int around(input int ctr, input int spread);
    int v;
    v = ctr + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int pick_center();
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 400)) - 200;
      1:       return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Queue one complete run under the current registers, samples clustered per axis.
  function automatic void push_run(input int spread);
    int n;
    foreach (run_ctr[i]) run_ctr[i] = pick_center();
    push_item(OpCalib, $urandom, $urandom, $urandom);
    repeat (int'(settle_cfg)) push_item(OpSample, $urandom, $urandom, $urandom);
    n = (count_cfg == '0) ? 1 : int'(count_cfg);
    repeat (n) begin
      push_item(OpSample, around(run_ctr[0], spread), around(run_ctr[1], spread),
                around(run_ctr[2], spread));
    end
    fed += 1 + int'(settle_cfg) + n;
  endfunction

  // Samples close to the latest offsets, so the dead zone edges get hit.
  function automatic void push_near(input int n);
    int spread;
    spread = int'(dz_cfg) + 4;
    repeat (n) begin
      push_item(OpSample, around(run_ctr[0], spread), around(run_ctr[1], spread),
                around(run_ctr[2], spread));
    end
    fed += n;
  endfunction

  function automatic void push_wild(input int n);
    repeat (n) push_item(OpSample, $urandom, $urandom, $urandom);
    fed += n;
  endfunction

  // Wait until everything queued is taken and answered, then let a division finish.
  task automatic drain();
    while (sample_q.size() != 0 || in_valid_i || pending_rates_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int          val;
    int unsigned eff;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    reg_read(RegDeadZone, 32'(DeadZoneRst));
    reg_read(RegCalib, 32'(CalibRst));
    reg_read(RegSettle, 32'(SettleRst));

    // Zero offsets: dead zone edges and full-scale samples.
    push_item(OpSample, 2, -2, 3);
    push_item(OpSample, -3, 4, -4);
    push_item(OpSample, 32767, -32768, 0);
    push_item(OpSample, -32768, 32767, -1);
    // Start a run under the reset settings, then shorten the settling while it waits.
    push_item(OpCalib, $urandom, $urandom, $urandom);
    drain();
    reg_write(RegDeadZone, 0);
    reg_write(RegSettle, 2);
    reg_write(RegCalib, 3);
    push_wild(2);
    // Offsets -32768, -2 (truncated toward zero from -7/3) and 32767.
    push_item(OpSample, -32768, -3, 32767);
    push_item(OpSample, -32768, -2, 32767);
    push_item(OpSample, -32768, -2, 32767);
    push_item(OpSample, 32767, 5, -32768);
    push_item(OpSample, -32768, -2, 32767);
    drain();
    reg_write(RegDeadZone, 32767);
    push_item(OpSample, 0, 32765, 32767);
    push_item(OpSample, -1, 32764, 0);
    drain();
    // No settling and a zero count: a single sample makes the offsets.
    reg_write(RegDeadZone, 5);
    reg_write(RegSettle, 0);
    reg_write(RegCalib, 0);
    push_item(OpCalib, $urandom, $urandom, $urandom);
    push_item(OpSample, 7, -7, 100);
    push_item(OpSample, 12, -12, 104);
    push_item(OpSample, 11, -3, 96);
    drain();
    // Restart a run halfway through.
    reg_write(RegSettle, 1);
    reg_write(RegCalib, 2);
    push_item(OpCalib, $urandom, $urandom, $urandom);
    push_wild(1);
    push_item(OpSample, 1000, 1000, 1000);
    push_item(OpCalib, $urandom, $urandom, $urandom);
    push_wild(1);
    push_item(OpSample, 10, 20, 30);
    push_item(OpSample, 11, 21, 31);
    push_item(OpSample, 0, 0, 0);
    drain();
    // Largest settling, cut short; largest count, then dropped below the counter.
    reg_write(RegSettle, 1023);
    push_item(OpCalib, $urandom, $urandom, $urandom);
    push_wild(3);
    drain();
    reg_write(RegSettle, 1);
    reg_write(RegCalib, 65535);
    repeat (6) push_item(OpSample, -1000, 999, -3);
    drain();
    reg_write(RegCalib, 2);
    push_item(OpSample, -1000, 999, -3);
    push_item(OpSample, 0, 0, 0);
    fed = 0;

    // Random phases; each ends idle so the registers can change, sometimes mid-run.
    while (fed < RandomItems) begin
      drain();
      if (fed >= RandomItems - 70) calm = 1'b1;
      case ($urandom_range(0, 7))
        0:       val = 0;
        1, 2, 3: val = $urandom_range(1, 40);
        4, 5:    val = $urandom_range(41, 2000);
        6:       val = $urandom_range(0, 32767);
        default: val = 32767;
      endcase
      reg_write(RegDeadZone, val);
      if ($urandom_range(0, 1) != 0) begin
        reg_write(RegSettle, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5));
      end
      if ($urandom_range(0, 1) != 0) begin
        val = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
        eff = (val == 0) ? 1 : val;
        // Keep the average of a cut-short run within the offset range.
        if (cal_phase != CAL_SUM || eff > run_cnt) reg_write(RegCalib, val);
      end
      repeat ($urandom_range(3, 6)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            push_run($urandom_range(0, 60));
            push_near($urandom_range(2, 6));
          end
          6, 7: push_wild($urandom_range(1, 4));
          8: begin
            // Broken run: start it and feed whatever comes.
            push_item(OpCalib, $urandom, $urandom, $urandom);
            fed++;
            push_wild($urandom_range(0, 4));
          end
          default: begin
            push_item(OpCalib, $urandom, $urandom, $urandom);
            fed++;
            push_run($urandom_range(0, 60));
            push_near($urandom_range(1, 4));
          end
        endcase
      end
    end
    drain();

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/rsoc_pkg.sv
src/rsoc_regs.sv
src/rsoc_div.sv
src/rsoc_ctrl.sv
src/rsoc_dp.sv
src/rate_sensor_offset_calib_deadzone_unit.sv
bench/tb_rate_sensor_offset_calib_deadzone_unit.sv
